// ===== design/apc_pkg.sv =====
// Shared types, constants and a helper function for the autoneg page classifier.
`default_nettype none

package apc_pkg;

   localparam int unsigned WordWidth = 16;
   localparam int unsigned MsgWidth  = 11;
   localparam int unsigned RspWidth  = 32;

   // codeword bit positions
   localparam int unsigned BitNp     = 15;
   localparam int unsigned BitAck    = 14;
   localparam int unsigned BitMp     = 13;
   localparam int unsigned BitAck2   = 12;
   localparam int unsigned BitToggle = 11;

   localparam logic [4:0]  SelBasePage = 5'd1;
   localparam logic [15:0] AckKeepMask = 16'hAFFF;   // all bits but ACK and ACK2

   localparam logic [MsgWidth-1:0] MsgGigabit = 11'd8;
   localparam logic [MsgWidth-1:0] MsgEee     = 11'd10;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_BASE = 2'd1,
      PH_ACK  = 2'd2,
      PH_NEXT = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      GRP_BASE = 2'd0,
      GRP_MSG  = 2'd1,
      GRP_UNF  = 2'd2
   } group_type;

   typedef enum logic [2:0] {
      K_BASE = 3'd0,
      K_ACK  = 3'd1,
      K_MSG  = 3'd2,
      K_UNF  = 3'd3,
      K_GT0  = 3'd4,
      K_GT1  = 3'd5,
      K_EEE  = 3'd6
   } kind_type;

   // one classified word, handed from the decoder to the result register
   typedef struct packed {
      kind_type               kind;
      group_type              grp;
      logic                   cont;
      logic [WordWidth-1:0]   word;
   } result_type;

   function automatic kind_type unf_kind(input logic [MsgWidth-1:0] msg,
                                         input logic [1:0] cnt);
      kind_type k;
      k = K_UNF;
      if (msg == MsgGigabit) begin
         if (cnt == 2'd0) k = K_GT0;
         else if (cnt == 2'd1) k = K_GT1;
      end else if (msg == MsgEee && cnt == 2'd0) begin
         k = K_EEE;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== design/autoneg_page_classifier.sv =====
// Top level of the autonegotiation link codeword page classifier.
//
// Usage:
//   req channel: one 16-bit link codeword per word (req_tdata[15:0]).
//   rsp channel: zero or one result word per codeword, giving the page kind,
//   packet group, a repeat flag, the echoed codeword and its NP/ACK/ACK2/
//   toggle bits. Codewords that fit no sequencing rule produce nothing.
// Timing:
//   Codeword is registered at req acceptance, classified combinationally from
//   that register against the page sequencing state, and lands in the result
//   register. One codeword per cycle is sustained while rsp_tready is high;
//   the only loop is the sequencing-state update (phase, held word and kind).
// Stall:
//   When rsp_tready is low and a result is waiting, any registered codeword
//   holds and drops req_tready; req_tready stays high while either the input
//   stage or the result register has room. No result is dropped or repeated.
// Reset:
//   Synchronous, active high. Clears both valid flags and returns sequencing
//   to idle (held word, message code, page counter cleared, group base).
`default_nettype none

module autoneg_page_classifier (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [15:0]  req_tdata,   // [15:0] codeword
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [31:0]  rsp_tdata    // [2:0] page_kind, [4:3] page_group, [5] continues,
                                     // [21:6] word_out, [22] ack_bit, [23] ack2_bit,
                                     // [24] toggle_bit, [25] next_page_bit, [31:26] zero
);

   logic                             in_valid_ff, in_valid_in;
   logic [apc_pkg::WordWidth-1:0]    in_word_ff;
   logic                             can_load;
   logic                             fire;
   logic                             hit;
   apc_pkg::result_type              result;

   // input stage drains whenever the result register can take its outcome
   assign fire       = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || can_load;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) in_valid_in = req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_word_ff <= req_tdata;
   end

   apc_classify u_classify (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .word   (in_word_ff),
      .hit    (hit),
      .result (result)
   );

   apc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (fire && hit),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== design/apc_classify.sv =====
// Page sequencing state and per-word classification logic.
`default_nettype none

module apc_classify (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             fire,     // registered word consumed this cycle
   input  wire  [apc_pkg::WordWidth-1:0]   word,
   output logic                            hit,      // word yields a result
   output apc_pkg::result_type             result
);

   apc_pkg::phase_type              phase_ff, phase_in;
   logic [apc_pkg::WordWidth-1:0]   held_ff, held_in;
   logic [apc_pkg::MsgWidth-1:0]    msg_ff, msg_in;
   logic [1:0]                      cnt_ff, cnt_in;
   apc_pkg::group_type              grp_ff, grp_in;
   apc_pkg::kind_type               hkind_ff, hkind_in;

   logic is_sel, is_ack, is_mp, is_same, ack_match;
   apc_pkg::kind_type ukind;

   assign is_sel    = (word[4:0] == apc_pkg::SelBasePage);
   assign is_ack    = word[apc_pkg::BitAck];
   assign is_mp     = word[apc_pkg::BitMp];
   assign is_same   = (word == held_ff);
   assign ack_match = is_ack &&
                      ((word & apc_pkg::AckKeepMask) == (held_ff & apc_pkg::AckKeepMask));
   assign ukind     = apc_pkg::unf_kind(msg_ff, cnt_ff);

   // next state
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      msg_in   = msg_ff;
      cnt_in   = cnt_ff;
      grp_in   = grp_ff;
      hkind_in = hkind_ff;
      if (fire) begin
         case (phase_ff)
            apc_pkg::PH_IDLE: begin
               if (is_sel) begin
                  phase_in = apc_pkg::PH_BASE;
                  held_in  = word;
                  hkind_in = apc_pkg::K_BASE;
               end
            end
            apc_pkg::PH_BASE: begin
               if (is_ack) begin
                  phase_in = apc_pkg::PH_ACK;
                  held_in  = word;
                  hkind_in = apc_pkg::K_ACK;
                  grp_in   = apc_pkg::GRP_BASE;
               end
            end
            apc_pkg::PH_ACK: begin
               if (!ack_match) begin
                  phase_in = apc_pkg::PH_NEXT;
                  held_in  = word;
                  if (is_mp) begin
                     msg_in   = word[apc_pkg::MsgWidth-1:0];
                     cnt_in   = 2'd0;
                     grp_in   = apc_pkg::GRP_MSG;
                     hkind_in = apc_pkg::K_MSG;
                  end else begin
                     if (cnt_ff != 2'd2) cnt_in = cnt_ff + 2'd1;
                     grp_in   = apc_pkg::GRP_UNF;
                     hkind_in = ukind;
                  end
               end
            end
            apc_pkg::PH_NEXT: begin
               if (is_ack) begin
                  phase_in = apc_pkg::PH_ACK;
                  held_in  = word;
                  hkind_in = apc_pkg::K_ACK;
               end
            end
            default: phase_in = apc_pkg::PH_IDLE;
         endcase
      end
   end

   // outputs
   always_comb begin
      hit         = 1'b0;
      result.kind = apc_pkg::K_BASE;
      result.grp  = apc_pkg::GRP_BASE;
      result.cont = 1'b0;
      result.word = word;
      case (phase_ff)
         apc_pkg::PH_IDLE: begin
            hit = is_sel;
         end
         apc_pkg::PH_BASE: begin
            if (is_ack) begin
               hit         = 1'b1;
               result.kind = apc_pkg::K_ACK;
            end else if (is_same) begin
               hit         = 1'b1;
               result.cont = 1'b1;
            end
         end
         apc_pkg::PH_ACK: begin
            hit = 1'b1;
            if (ack_match) begin
               result.kind = apc_pkg::K_ACK;
               result.grp  = grp_ff;
               result.cont = 1'b1;
            end else if (is_mp) begin
               result.kind = apc_pkg::K_MSG;
               result.grp  = apc_pkg::GRP_MSG;
            end else begin
               result.kind = ukind;
               result.grp  = apc_pkg::GRP_UNF;
            end
         end
         apc_pkg::PH_NEXT: begin
            if (is_ack) begin
               hit         = 1'b1;
               result.kind = apc_pkg::K_ACK;
               result.grp  = grp_ff;
            end else if (is_same) begin
               hit         = 1'b1;
               result.kind = hkind_ff;
               result.grp  = grp_ff;
               result.cont = 1'b1;
            end
         end
         default: hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= apc_pkg::PH_IDLE;
         held_ff  <= '0;
         msg_ff   <= '0;
         cnt_ff   <= 2'd0;
         grp_ff   <= apc_pkg::GRP_BASE;
         hkind_ff <= apc_pkg::K_BASE;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         msg_ff   <= msg_in;
         cnt_ff   <= cnt_in;
         grp_ff   <= grp_in;
         hkind_ff <= hkind_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/apc_out_reg.sv =====
// Result register driving the rsp stream, with field packing.
`default_nettype none

module apc_out_reg (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                load,
   input  apc_pkg::result_type                result,
   output logic                               can_load,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [apc_pkg::RspWidth-1:0]       rsp_tdata
);

   logic                             valid_ff, valid_in;
   logic [apc_pkg::RspWidth-1:0]     data_ff, data_in;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) valid_in = load;
   end

   always_comb begin
      data_in = '0;
      data_in[2:0]   = result.kind;
      data_in[4:3]   = result.grp;
      data_in[5]     = result.cont;
      data_in[21:6]  = result.word;
      data_in[22]    = result.word[apc_pkg::BitAck];
      data_in[23]    = result.word[apc_pkg::BitAck2];
      data_in[24]    = result.word[apc_pkg::BitToggle];
      data_in[25]    = result.word[apc_pkg::BitNp];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && load) data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

// ===== design/apc_checker.sv =====
// Port-level assertions for the page classifier, bound to the top level.
`default_nettype none

module apc_checker (
   input wire          clock,
   input wire          reset,
   input wire          req_tready,
   input wire          rsp_tvalid,
   input wire          rsp_tready,
   input wire  [31:0]  rsp_tdata
);

   // a pending result must not change while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("rsp word changed while stalled");

   // with the result register empty the input side must have room
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty result register");

   // flag bits agree with the echoed codeword
   a_flag_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[22] == rsp_tdata[20] && rsp_tdata[23] == rsp_tdata[18] &&
                      rsp_tdata[24] == rsp_tdata[17] && rsp_tdata[25] == rsp_tdata[21]))
      else $error("flag bits disagree with echoed codeword");

   // legal kind and group codes, padding clear
   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] != 3'd7 && rsp_tdata[4:3] != 2'd3 &&
                      rsp_tdata[31:26] == 6'd0))
      else $error("illegal kind, group or padding");

endmodule

bind autoneg_page_classifier apc_checker u_apc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
